// ===== rtl/core/swm_pkg.sv =====
// Shared types and constants for the swerve module kinematics block.
`timescale 1ns / 1ps

package swm_pkg;

  // Number of swerve modules handled side by side.
  localparam int MODULES = 4;

  // Working width of the module velocity vector and the CORDIC datapath.
  localparam int VEL_W = 44;
  // Width of a steering encoder count.
  localparam int CNT_W = 32;
  // Width of the CORDIC magnitude after gain correction.
  localparam int MAG_W = 42;
  // Width of the rpm numerator (magnitude times sixty).
  localparam int RNUM_W = 48;
  // Width of the wheel radius and gear ratio registers.
  localparam int RATIO_W = 10;
  localparam int SPAN_W  = 12;

  // CORDIC gain correction, Q16.
  localparam logic [15:0] CORDIC_GAIN = 16'd39796;
  // One over two pi, Q32.
  localparam logic [29:0] INV_TWO_PI = 30'd683565276;
  // Magnitude used when the rpm quotient is far out of range.
  localparam logic [16:0] RPM_SAT = 17'd40000;

  // Arctangent of 2^-i as a binary angle (2^32 is one turn).
  localparam logic [31:0] ATAN_TAB [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // Corner signs: bit m set means mx = vx + w*W (module on the right side).
  localparam logic [MODULES-1:0] MX_ADD_WW = 4'b0110;
  // Bit m set means my = vy - w*L (module at the rear).
  localparam logic [MODULES-1:0] MY_SUB_WL = 4'b1100;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_HALF_LENGTH  = 2'd0,
    REG_HALF_WIDTH   = 2'd1,
    REG_STEER_RATIO  = 2'd2,
    REG_WHEEL_RADIUS = 2'd3
  } reg_idx_t;

  // Input word.
  typedef struct packed {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] vw;
    logic [11:0]        speed_gain;
    logic signed [31:0] steer_count_0;
    logic signed [31:0] steer_count_1;
    logic signed [31:0] steer_count_2;
    logic signed [31:0] steer_count_3;
  } in_t;

  // Output word.
  typedef struct packed {
    logic signed [15:0] drive_rpm_0;
    logic signed [15:0] drive_rpm_1;
    logic signed [15:0] drive_rpm_2;
    logic signed [15:0] drive_rpm_3;
    logic signed [31:0] steer_target_0;
    logic signed [31:0] steer_target_1;
    logic signed [31:0] steer_target_2;
    logic signed [31:0] steer_target_3;
  } out_t;

endpackage

// ===== rtl/core/swerve_module_kinematics.sv =====
// Top level of the swerve drive inverse kinematics block.
//
// Usage: the input channel (in_valid, in_stall, in_data) takes one word with the body
// command (vx, vy, vw), a Q8 speed gain and the four steering encoder counts. The
// output channel (out_valid, out_stall, out_data) returns one word per input word
// with a saturated wheel rpm and an absolute steering target for each module, in the
// order front left, front right, rear right, rear left.
// Throughput is one word per cycle while the receiver does not stall. The pipeline
// has three command stages, the 32-stage count divider, one fold stage, the
// CORDIC stages, five heading stages, the 48-stage rpm divider and two rpm scaling
// stages.
// Four lanes work side by side, one per module; the output word merges them.
// When the receiver stalls a valid output word, the whole pipeline holds and in_stall
// rises with it; the waiting word does not change.
// The APB port writes and reads the geometry, gear ratio and wheel radius; write
// them only while no word is in flight. Reset clears the pipeline and loads the
// default geometry (500 mm, 500 mm, ratio 144, radius 55 mm).
`timescale 1ns / 1ps

module swerve_module_kinematics #(
  parameter int ENCODER_COUNTS = 8192,
  parameter int CORDIC_STAGES  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  swm_pkg::in_t         in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output swm_pkg::out_t        out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int TW  = $clog2(ENCODER_COUNTS + 1) + swm_pkg::RATIO_W;
  localparam int VW  = swm_pkg::VEL_W;
  localparam int NM  = swm_pkg::MODULES;
  localparam int LAT = 3 + swm_pkg::CNT_W + 1 + CORDIC_STAGES + 5 + swm_pkg::RNUM_W + 2;

  // Configuration registers.
  logic [swm_pkg::SPAN_W-1:0]  half_length;
  logic [swm_pkg::SPAN_W-1:0]  half_width;
  logic [swm_pkg::RATIO_W-1:0] steer_ratio;
  logic [swm_pkg::RATIO_W-1:0] rim_radius;
  swm_pkg::reg_idx_t           reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = swm_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      half_length  <= 12'd500;
      half_width   <= 12'd500;
      steer_ratio  <= 10'd144;
      rim_radius   <= 10'd55;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        swm_pkg::REG_HALF_LENGTH:  half_length  <= pwdata[11:0];
        swm_pkg::REG_HALF_WIDTH:   half_width   <= pwdata[11:0];
        swm_pkg::REG_STEER_RATIO:  steer_ratio  <= pwdata[9:0];
        swm_pkg::REG_WHEEL_RADIUS: rim_radius   <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (reg_idx)
      swm_pkg::REG_HALF_LENGTH:  prdata = 32'(half_length);
      swm_pkg::REG_HALF_WIDTH:   prdata = 32'(half_width);
      swm_pkg::REG_STEER_RATIO:  prdata = 32'(steer_ratio);
      swm_pkg::REG_WHEEL_RADIUS: prdata = 32'(rim_radius);
      default:                   prdata = 32'd0;
    endcase
  end

  // Derived constants: counts per wheel turn and the effective radius.
  logic [TW-1:0]               turn_counts;
  logic [swm_pkg::RATIO_W-1:0] radius_eff;
  logic [swm_pkg::RATIO_W-1:0] ratio_eff;

  assign ratio_eff = (steer_ratio == '0) ? 10'd1 : steer_ratio;

  always_ff @(posedge clk) begin
    turn_counts <= TW'(ENCODER_COUNTS) * TW'(ratio_eff);
    radius_eff  <= (rim_radius == '0) ? 10'd1 : rim_radius;
  end

  // Pipeline advance and word tracking.
  logic           adv;
  logic [LAT-1:0] vld;

  assign out_valid = vld[LAT-1];
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  logic signed [31:0] in_cnt [NM];

  assign in_cnt[0] = in_data.steer_count_0;
  assign in_cnt[1] = in_data.steer_count_1;
  assign in_cnt[2] = in_data.steer_count_2;
  assign in_cnt[3] = in_data.steer_count_3;

  // Command times gain.
  logic signed [28:0] s1_vxg;
  logic signed [28:0] s1_vyg;
  logic signed [28:0] s1_w;
  logic signed [31:0] s1_cnt [NM];

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_vxg <= in_data.vx * $signed({1'b0, in_data.speed_gain});
      s1_vyg <= in_data.vy * $signed({1'b0, in_data.speed_gain});
      s1_w   <= in_data.vw * $signed({1'b0, in_data.speed_gain});
      s1_cnt <= in_cnt;
    end
  end

  // Translation in micro units and the rotation terms at the corners.
  logic signed [VW-1:0] s2_vxs;
  logic signed [VW-1:0] s2_vys;
  logic signed [VW-1:0] s2_wl;
  logic signed [VW-1:0] s2_ww;
  logic signed [31:0]   s2_cnt [NM];

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_vxs <= s1_vxg * 44'sd1000;
      s2_vys <= s1_vyg * 44'sd1000;
      s2_wl  <= s1_w * $signed({1'b0, half_length});
      s2_ww  <= s1_w * $signed({1'b0, half_width});
      s2_cnt <= s1_cnt;
    end
  end

  // Per-module velocity vectors.
  logic signed [VW-1:0] s3_mx  [NM];
  logic signed [VW-1:0] s3_my  [NM];
  logic signed [31:0]   s3_cnt [NM];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int m = 0; m < NM; m++) begin
        s3_mx[m] <= swm_pkg::MX_ADD_WW[m] ? s2_vxs + s2_ww : s2_vxs - s2_ww;
        s3_my[m] <= swm_pkg::MY_SUB_WL[m] ? s2_vys - s2_wl : s2_vys + s2_wl;
      end
      s3_cnt <= s2_cnt;
    end
  end

  // One lane per module.
  logic signed [15:0] lane_rpm [NM];
  logic signed [31:0] lane_tgt [NM];

  for (genvar m = 0; m < NM; m++) begin : g_lane
    swm_lane #(
      .TURN_W        (TW),
      .CORDIC_STAGES (CORDIC_STAGES)
    ) u_lane (
      .clk         (clk),
      .en          (adv),
      .turn_counts (turn_counts),
      .radius      (radius_eff),
      .mx          (s3_mx[m]),
      .my          (s3_my[m]),
      .cnt         (s3_cnt[m]),
      .rpm         (lane_rpm[m]),
      .tgt         (lane_tgt[m])
    );
  end

  // Merge the lanes into the output word.
  assign out_data.drive_rpm_0    = lane_rpm[0];
  assign out_data.drive_rpm_1    = lane_rpm[1];
  assign out_data.drive_rpm_2    = lane_rpm[2];
  assign out_data.drive_rpm_3    = lane_rpm[3];
  assign out_data.steer_target_0 = lane_tgt[0];
  assign out_data.steer_target_1 = lane_tgt[1];
  assign out_data.steer_target_2 = lane_tgt[2];
  assign out_data.steer_target_3 = lane_tgt[3];

endmodule

// ===== rtl/core/swm_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
`timescale 1ns / 1ps

module swm_div #(
  parameter int NUM_W  = 32,
  parameter int DEN_W  = 10,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              en,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic [NUM_W-1:0]  quo,
  output logic [DEN_W-1:0]  rem,
  output logic [SIDE_W-1:0] side_out
);

  // Per-stage partial remainder, shifting numerator/quotient and sideband.
  logic [DEN_W-1:0]  part [NUM_W];
  logic [NUM_W-1:0]  nq   [NUM_W];
  logic [SIDE_W-1:0] sd   [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_step
    logic [DEN_W-1:0]  part_in;
    logic [NUM_W-1:0]  nq_in;
    logic [SIDE_W-1:0] sd_in;
    logic [DEN_W:0]    trial;
    logic              fits;

    if (k == 0) begin : g_first
      assign part_in = '0;
      assign nq_in   = num;
      assign sd_in   = side_in;
    end else begin : g_next
      assign part_in = part[k-1];
      assign nq_in   = nq[k-1];
      assign sd_in   = sd[k-1];
    end

    // Bring down the next numerator bit and try the subtraction.
    assign trial = {part_in, nq_in[NUM_W-1]};
    assign fits  = (trial >= {1'b0, den});

    always_ff @(posedge clk) begin
      if (en) begin
        part[k] <= fits ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
        nq[k]   <= {nq_in[NUM_W-2:0], fits};
        sd[k]   <= sd_in;
      end
    end
  end

  assign quo      = nq[NUM_W-1];
  assign rem      = part[NUM_W-1];
  assign side_out = sd[NUM_W-1];

endmodule

// ===== rtl/core/swm_cordic.sv =====
// Pipelined vectoring CORDIC: one micro-rotation per stage.
`timescale 1ns / 1ps

module swm_cordic #(
  parameter int STAGES = 16,
  parameter int SIDE_W = 1
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [swm_pkg::VEL_W-1:0] x_in,
  input  logic signed [swm_pkg::VEL_W-1:0] y_in,
  input  logic [31:0]                     z_in,
  input  logic [SIDE_W-1:0]               side_in,
  output logic signed [swm_pkg::VEL_W-1:0] x_out,
  output logic [31:0]                     z_out,
  output logic [SIDE_W-1:0]               side_out
);

  logic signed [swm_pkg::VEL_W-1:0] xs [STAGES];
  logic signed [swm_pkg::VEL_W-1:0] ys [STAGES];
  logic [31:0]                      zs [STAGES];
  logic [SIDE_W-1:0]                sd [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [swm_pkg::VEL_W-1:0] x_cur;
    logic signed [swm_pkg::VEL_W-1:0] y_cur;
    logic [31:0]                      z_cur;
    logic [SIDE_W-1:0]                sd_cur;

    if (i == 0) begin : g_first
      assign x_cur  = x_in;
      assign y_cur  = y_in;
      assign z_cur  = z_in;
      assign sd_cur = side_in;
    end else begin : g_next
      assign x_cur  = xs[i-1];
      assign y_cur  = ys[i-1];
      assign z_cur  = zs[i-1];
      assign sd_cur = sd[i-1];
    end

    // Rotate toward the x axis; the shifts round toward minus infinity.
    always_ff @(posedge clk) begin
      if (en) begin
        if (!y_cur[swm_pkg::VEL_W-1]) begin
          xs[i] <= x_cur + (y_cur >>> i);
          ys[i] <= y_cur - (x_cur >>> i);
          zs[i] <= z_cur + swm_pkg::ATAN_TAB[i];
        end else begin
          xs[i] <= x_cur - (y_cur >>> i);
          ys[i] <= y_cur + (x_cur >>> i);
          zs[i] <= z_cur - swm_pkg::ATAN_TAB[i];
        end
        sd[i] <= sd_cur;
      end
    end
  end

  assign x_out    = xs[STAGES-1];
  assign z_out    = zs[STAGES-1];
  assign side_out = sd[STAGES-1];

endmodule

// ===== rtl/core/swm_lane.sv =====
// One module lane: heading, magnitude, flip decision, rpm and steering target.
`timescale 1ns / 1ps

module swm_lane #(
  parameter int TURN_W        = 27,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic [TURN_W-1:0]                turn_counts,
  input  logic [swm_pkg::RATIO_W-1:0]      radius,
  input  logic signed [swm_pkg::VEL_W-1:0] mx,
  input  logic signed [swm_pkg::VEL_W-1:0] my,
  input  logic signed [31:0]               cnt,
  output logic signed [15:0]               rpm,
  output logic signed [31:0]               tgt
);

  localparam int VW  = swm_pkg::VEL_W;
  localparam int QW  = TURN_W + 2;
  localparam int EW  = QW + 1;
  localparam int ZPW = 32 + QW;

  typedef struct packed {
    logic signed [31:0]    cnt;
    logic signed [VW-1:0]  mx;
    logic signed [VW-1:0]  my;
  } pre_t;

  typedef struct packed {
    logic                  zero;
    logic signed [31:0]    cnt;
    logic [TURN_W-1:0]     cm;
  } rot_t;

  typedef struct packed {
    logic                  flip;
    logic signed [31:0]    tgt;
  } spd_t;

  logic [QW-1:0] q_counts;
  assign q_counts = {turn_counts, 2'b00};

  // Encoder count reduced modulo one wheel turn.
  pre_t              pre_in;
  pre_t              pre_out;
  logic [31:0]       cnt_abs;
  logic [31:0]       cnt_quo;
  logic [TURN_W-1:0] cnt_rem;

  assign cnt_abs = cnt[31] ? $unsigned(-cnt) : $unsigned(cnt);
  assign pre_in  = '{cnt: cnt, mx: mx, my: my};

  swm_div #(
    .NUM_W  (swm_pkg::CNT_W),
    .DEN_W  (TURN_W),
    .SIDE_W ($bits(pre_t))
  ) u_cnt_div (
    .clk      (clk),
    .en       (en),
    .num      (cnt_abs),
    .den      (turn_counts),
    .side_in  (pre_in),
    .quo      (cnt_quo),
    .rem      (cnt_rem),
    .side_out (pre_out)
  );

  // Fold negative counts into [0, T) and move the vector into the right half plane.
  logic signed [VW-1:0] px0;
  logic signed [VW-1:0] py0;
  logic [31:0]          pz0;
  rot_t                 prs;
  logic                 cnt_neg_unused;

  assign cnt_neg_unused = cnt_quo[0];

  always_ff @(posedge clk) begin
    if (en) begin
      if (pre_out.mx < 0) begin
        px0 <= -pre_out.mx;
        py0 <= -pre_out.my;
        pz0 <= 32'h8000_0000;
      end else begin
        px0 <= pre_out.mx;
        py0 <= pre_out.my;
        pz0 <= 32'h0000_0000;
      end
      prs.zero <= (pre_out.mx == '0) && (pre_out.my == '0);
      prs.cnt  <= pre_out.cnt;
      if (pre_out.cnt[31] && (cnt_rem != '0)) begin
        prs.cm <= turn_counts - cnt_rem;
      end else begin
        prs.cm <= cnt_rem;
      end
    end
  end

  logic signed [VW-1:0] cx;
  logic [31:0]          cz;
  rot_t                 crs;

  swm_cordic #(
    .STAGES (CORDIC_STAGES),
    .SIDE_W ($bits(rot_t))
  ) u_cordic (
    .clk      (clk),
    .en       (en),
    .x_in     (px0),
    .y_in     (py0),
    .z_in     (pz0),
    .side_in  (prs),
    .x_out    (cx),
    .z_out    (cz),
    .side_out (crs)
  );

  // Gain correction partial products and heading scaled to quarter counts.
  logic [36:0]        p1_mh;
  logic [36:0]        p1_ml;
  logic [ZPW-1:0]     p1_zp;
  logic               p1_zero;
  logic signed [31:0] p1_cnt;
  logic [TURN_W-1:0]  p1_cm;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_mh   <= 37'(cx[41:21]) * 37'(swm_pkg::CORDIC_GAIN);
      p1_ml   <= 37'(cx[20:0]) * 37'(swm_pkg::CORDIC_GAIN);
      p1_zp   <= ZPW'(crs.zero ? 32'd0 : cz) * ZPW'(q_counts);
      p1_zero <= crs.zero;
      p1_cnt  <= crs.cnt;
      p1_cm   <= crs.cm;
    end
  end

  // Rounded magnitude and rounded heading.
  logic [57:0]                 mag_sum;
  logic [ZPW-1:0]              tq_sum;
  logic [swm_pkg::MAG_W-1:0]   p2_mag;
  logic [QW-1:0]               p2_tq;
  logic signed [31:0]          p2_cnt;
  logic [TURN_W-1:0]           p2_cm;

  assign mag_sum = {p1_mh, 21'd0} + 58'(p1_ml) + 58'd32768;
  assign tq_sum  = p1_zp + ZPW'(33'h0_8000_0000);

  always_ff @(posedge clk) begin
    if (en) begin
      p2_mag <= p1_zero ? '0 : mag_sum[57:16];
      p2_tq  <= tq_sum[ZPW-1:32];
      p2_cnt <= p1_cnt;
      p2_cm  <= p1_cm;
    end
  end

  // Heading error reduced modulo a full turn, and magnitude times sixty.
  logic signed [QW:0]          err_raw;
  logic signed [QW:0]          q_s;
  logic [QW-1:0]               p3_r;
  logic [swm_pkg::RNUM_W-1:0]  p3_num;
  logic signed [31:0]          p3_cnt;

  assign err_raw = $signed({1'b0, p2_tq}) - $signed({1'b0, p2_cm, 2'b00});
  assign q_s     = $signed({1'b0, q_counts});

  always_ff @(posedge clk) begin
    if (en) begin
      if (err_raw < 0) begin
        p3_r <= QW'(err_raw + q_s);
      end else if (err_raw >= q_s) begin
        p3_r <= QW'(err_raw - q_s);
      end else begin
        p3_r <= QW'(err_raw);
      end
      p3_num <= {p2_mag, 6'd0} - {4'd0, p2_mag, 2'b00};
      p3_cnt <= p2_cnt;
    end
  end

  // Wrap into a half turn either way, then flip past a quarter turn.
  logic signed [EW-1:0]        r_s;
  logic signed [EW-1:0]        t_s;
  logic signed [EW-1:0]        t2_s;
  logic signed [EW-1:0]        qe_s;
  logic signed [EW-1:0]        e_wrap;
  logic signed [EW-1:0]        p4_e;
  logic                        p4_flip;
  logic [swm_pkg::RNUM_W-1:0]  p4_num;
  logic signed [31:0]          p4_cnt;

  assign r_s    = $signed({1'b0, p3_r});
  assign t_s    = $signed({3'b000, turn_counts});
  assign t2_s   = $signed({2'b00, turn_counts, 1'b0});
  assign qe_s   = $signed({1'b0, q_counts});
  assign e_wrap = (r_s <= t2_s) ? r_s : r_s - qe_s;

  always_ff @(posedge clk) begin
    if (en) begin
      if (e_wrap > t_s) begin
        p4_e    <= e_wrap - t2_s;
        p4_flip <= 1'b1;
      end else if (e_wrap < -t_s) begin
        p4_e    <= e_wrap + t2_s;
        p4_flip <= 1'b1;
      end else begin
        p4_e    <= e_wrap;
        p4_flip <= 1'b0;
      end
      p4_num <= p3_num;
      p4_cnt <= p3_cnt;
    end
  end

  // Absolute steering target, rounded to whole counts and saturated.
  logic signed [EW-1:0]        e_step;
  logic signed [33:0]          tgt_sum;
  logic signed [31:0]          p5_tgt;
  logic                        p5_flip;
  logic [swm_pkg::RNUM_W-1:0]  p5_num;

  assign e_step  = (p4_e + EW'(2)) >>> 2;
  assign tgt_sum = 34'(p4_cnt) + 34'(e_step);

  always_ff @(posedge clk) begin
    if (en) begin
      if (tgt_sum[33] && !(tgt_sum[32] && tgt_sum[31])) begin
        p5_tgt <= 32'sh8000_0000;
      end else if (!tgt_sum[33] && (tgt_sum[32] || tgt_sum[31])) begin
        p5_tgt <= 32'sh7FFF_FFFF;
      end else begin
        p5_tgt <= tgt_sum[31:0];
      end
      p5_flip <= p4_flip;
      p5_num  <= p4_num;
    end
  end

  // Linear speed divided by the wheel radius.
  spd_t                        spd_in;
  spd_t                        spd_out;
  logic [swm_pkg::RNUM_W-1:0]  q_spd;
  logic [swm_pkg::RATIO_W-1:0] q_rem_unused;

  assign spd_in = '{flip: p5_flip, tgt: p5_tgt};

  swm_div #(
    .NUM_W  (swm_pkg::RNUM_W),
    .DEN_W  (swm_pkg::RATIO_W),
    .SIDE_W ($bits(spd_t))
  ) u_rpm_div (
    .clk      (clk),
    .en       (en),
    .num      (p5_num),
    .den      (radius),
    .side_in  (spd_in),
    .quo      (q_spd),
    .rem      (q_rem_unused),
    .side_out (spd_out)
  );

  // Scale by one over two pi in two partial products.
  logic               r1_sat;
  logic [47:0]        r1_ph;
  logic [47:0]        r1_pl;
  logic               r1_flip;
  logic signed [31:0] r1_tgt;

  always_ff @(posedge clk) begin
    if (en) begin
      r1_sat  <= |q_spd[47:36];
      r1_ph   <= 48'(q_spd[35:18]) * 48'(swm_pkg::INV_TWO_PI);
      r1_pl   <= 48'(q_spd[17:0]) * 48'(swm_pkg::INV_TWO_PI);
      r1_flip <= spd_out.flip;
      r1_tgt  <= spd_out.tgt;
    end
  end

  // Round, apply the flip and saturate to 16 bits.
  logic [48:0] rsum;
  logic [16:0] rmag;

  assign rsum = {1'b0, r1_ph} + 49'h0_8000_0000 + 49'(r1_pl[47:18]);
  assign rmag = r1_sat ? swm_pkg::RPM_SAT : rsum[48:32];

  always_ff @(posedge clk) begin
    if (en) begin
      if (r1_flip) begin
        rpm <= (rmag >= 17'd32768) ? 16'sh8000 : $signed(16'(17'd0 - rmag));
      end else begin
        rpm <= (rmag > 17'd32767) ? 16'sh7FFF : $signed(rmag[15:0]);
      end
      tgt <= r1_tgt;
    end
  end

endmodule

// ===== bench/swerve_module_kinematics_tb.sv =====
// Self-checking testbench for the swerve module kinematics block.
`timescale 1ns / 1ps

module swerve_module_kinematics_tb;

  localparam int ENC_COUNTS  = 8192;
  localparam int CORDIC_STGS = 16;
  localparam int PIPE_LAT    = 91 + CORDIC_STGS;
  localparam int CYCLE_LIMIT = 1500000;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_stall;
  swm_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  swm_pkg::out_t out_data;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [3:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  // Shadow copy of the geometry registers.
  logic [11:0] cfg_half_len = 12'd500;
  logic [11:0] cfg_half_wid = 12'd500;
  logic [9:0]  cfg_ratio    = 10'd144;
  logic [9:0]  cfg_radius   = 10'd55;

  swm_pkg::in_t  cmd_queue[$];
  swm_pkg::out_t wheel_expect[$];
  int   errors = 0;
  int   words_sent = 0;
  int   cycles = 0;

  swerve_module_kinematics #(
    .ENCODER_COUNTS(ENC_COUNTS),
    .CORDIC_STAGES (CORDIC_STGS)
  ) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Wheel rpm and steering targets for one command word.
  function automatic swm_pkg::out_t predict_wheels(swm_pkg::in_t w);
    longint g, vxs, vys, wr, span_t, span_q, mx, my, cnt, x, y, dx, dy;
    longint tq, cm, r, e, tgt, rpm;
    longint px[4], py[4];
    longint unsigned mag, q, hi, lo, rmag, radius, zu;
    logic [31:0] z;
    bit flip;
    logic signed [15:0] rpms[4];
    logic signed [31:0] tgts[4];
    swm_pkg::out_t o;
    g = longint'(w.speed_gain);
    vxs = longint'(w.vx) * g * 1000;
    vys = longint'(w.vy) * g * 1000;
    wr  = longint'(w.vw) * g;
    span_t = longint'(ENC_COUNTS) * ((cfg_ratio != 0) ? longint'(cfg_ratio) : 1);
    span_q = 4 * span_t;
    radius = (cfg_radius != 0) ? longint'(cfg_radius) : 1;
    px[0] = longint'(cfg_half_len);  px[1] = longint'(cfg_half_len);
    px[2] = -longint'(cfg_half_len); px[3] = -longint'(cfg_half_len);
    py[0] = longint'(cfg_half_wid);  py[1] = -longint'(cfg_half_wid);
    py[2] = -longint'(cfg_half_wid); py[3] = longint'(cfg_half_wid);
    for (int m = 0; m < swm_pkg::MODULES; m++) begin
      mx = vxs - wr * py[m];
      my = vys + wr * px[m];
      case (m)
        0: cnt = longint'(w.steer_count_0);
        1: cnt = longint'(w.steer_count_1);
        2: cnt = longint'(w.steer_count_2);
        default: cnt = longint'(w.steer_count_3);
      endcase
      // Vectoring CORDIC; a zero vector gives zero heading and magnitude.
      x = mx; y = my; z = '0; mag = 0;
      if (x != 0 || y != 0) begin
        if (x < 0) begin
          x = -x; y = -y; z = 32'h8000_0000;
        end
        for (int i = 0; i < CORDIC_STGS; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (y >= 0) begin
            x = x + dx; y = y - dy; z = z + swm_pkg::ATAN_TAB[i];
          end else begin
            x = x - dx; y = y + dy; z = z - swm_pkg::ATAN_TAB[i];
          end
        end
        mag = (longint'(x) * 39796 + 32768) >> 16;
      end
      // Heading error in quarter counts, wrapped and flipped.
      zu = 64'(z);
      tq = longint'((zu * span_q + 64'h8000_0000) >> 32);
      cm = cnt % span_t;
      if (cm < 0) cm = cm + span_t;
      r = (tq + span_q - 4 * cm) % span_q;
      e = (r <= 2 * span_t) ? r : r - span_q;
      flip = 1'b0;
      if (e > span_t) begin
        e = e - 2 * span_t; flip = 1'b1;
      end else if (e < -span_t) begin
        e = e + 2 * span_t; flip = 1'b1;
      end
      tgt = cnt + (e + 2 + span_q) / 4 - span_t;
      if (tgt > 64'sd2147483647) tgt = 64'sd2147483647;
      if (tgt < -64'sd2147483648) tgt = -64'sd2147483648;
      // Wheel speed in rpm.
      q = (mag * 60) / radius;
      if (q >= (64'd1 << 36)) begin
        rmag = 40000;
      end else begin
        hi = q >> 18;
        lo = q & 64'h3FFFF;
        rmag = (hi * 683565276 + 64'h8000_0000 + ((lo * 683565276) >> 18)) >> 32;
      end
      if (flip) rpm = (rmag > 32768) ? -32768 : -longint'(rmag);
      else      rpm = (rmag > 32767) ? 32767 : longint'(rmag);
      rpms[m] = rpm[15:0];
      tgts[m] = tgt[31:0];
    end
    o.drive_rpm_0 = rpms[0]; o.drive_rpm_1 = rpms[1];
    o.drive_rpm_2 = rpms[2]; o.drive_rpm_3 = rpms[3];
    o.steer_target_0 = tgts[0]; o.steer_target_1 = tgts[1];
    o.steer_target_2 = tgts[2]; o.steer_target_3 = tgts[3];
    return o;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        wheel_expect.push_back(predict_wheels(in_data));
        words_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (cmd_queue.size() > 0) begin
          in_data <= cmd_queue.pop_front();
          in_valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern, with one long hold-off once traffic is flowing.
  int stall_mode = 0;
  int mode_left = 0;
  int long_hold = 0;
  bit long_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (!long_done && words_sent >= 300) begin
        long_done = 1'b1;
        long_hold = 400;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      if (long_hold > 0) begin
        long_hold--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 9) < 3);
          2: out_stall <= (cycles % 7) < 3;
          default: out_stall <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Result checker: each accepted word against the oldest prediction.
  always @(posedge clk) begin
    swm_pkg::out_t ex;
    if (!rst && out_valid && !out_stall) begin
      if (wheel_expect.size() == 0) begin
        $error("unexpected result word");
        errors++;
      end else begin
        ex = wheel_expect.pop_front();
        check_field("drive_rpm_0", ex.drive_rpm_0, out_data.drive_rpm_0);
        check_field("drive_rpm_1", ex.drive_rpm_1, out_data.drive_rpm_1);
        check_field("drive_rpm_2", ex.drive_rpm_2, out_data.drive_rpm_2);
        check_field("drive_rpm_3", ex.drive_rpm_3, out_data.drive_rpm_3);
        check_field("steer_target_0", ex.steer_target_0, out_data.steer_target_0);
        check_field("steer_target_1", ex.steer_target_1, out_data.steer_target_1);
        check_field("steer_target_2", ex.steer_target_2, out_data.steer_target_2);
        check_field("steer_target_3", ex.steer_target_3, out_data.steer_target_3);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // One APB write: setup cycle, then access cycle.
  task automatic cfg_write(swm_pkg::reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      swm_pkg::REG_HALF_LENGTH:  cfg_half_len = value[11:0];
      swm_pkg::REG_HALF_WIDTH:   cfg_half_wid = value[11:0];
      swm_pkg::REG_STEER_RATIO:  cfg_ratio    = value[9:0];
      default:                   cfg_radius   = value[9:0];
    endcase
  endtask

  task automatic set_geometry(int l, int w, int ratio, int radius);
    cfg_write(swm_pkg::REG_HALF_LENGTH, l);
    cfg_write(swm_pkg::REG_HALF_WIDTH, w);
    cfg_write(swm_pkg::REG_STEER_RATIO, ratio);
    cfg_write(swm_pkg::REG_WHEEL_RADIUS, radius);
  endtask

  // Wait until every word has been sent and answered, then let the pipe drain.
  task automatic drain();
    while (cmd_queue.size() > 0 || in_valid || wheel_expect.size() > 0) @(posedge clk);
    repeat (PIPE_LAT + 20) @(posedge clk);
  endtask

  function automatic swm_pkg::in_t make_cmd(int sx, int sy, int sw, int gain, int c0,
                                            int c1, int c2, int c3);
    swm_pkg::in_t c;
    c.vx = 16'(sx); c.vy = 16'(sy); c.vw = 16'(sw); c.speed_gain = 12'(gain);
    c.steer_count_0 = c0; c.steer_count_1 = c1;
    c.steer_count_2 = c2; c.steer_count_3 = c3;
    return c;
  endfunction

  // Mostly moderate commands, some with full-range random bits.
  function automatic swm_pkg::in_t random_cmd();
    swm_pkg::in_t c;
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    c = raw[$bits(swm_pkg::in_t)-1:0];
    case ($urandom_range(0, 3))
      0: ;
      1: begin
        c.vx = 16'($signed($urandom_range(0, 8191)) - 4096);
        c.vy = 16'($signed($urandom_range(0, 8191)) - 4096);
        c.vw = 16'($signed($urandom_range(0, 8191)) - 4096);
        c.speed_gain = 12'($urandom_range(0, 2560));
        c.steer_count_0 = $signed($urandom_range(0, 4000000)) - 2000000;
        c.steer_count_1 = $signed($urandom_range(0, 4000000)) - 2000000;
      end
      2: begin
        c.speed_gain = 12'($urandom_range(0, 2560));
        if ($urandom_range(0, 1)) c.vw = '0;
        else begin c.vx = '0; c.vy = '0; end
      end
      default: c.speed_gain = 12'($urandom_range(200, 300));
    endcase
    return c;
  endfunction

  initial begin
    int half_t;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed words at the reset geometry.
    half_t = ENC_COUNTS * 144 / 2;
    cmd_queue.push_back(make_cmd(0, 0, 0, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(0, 0, 0, 4095, 123, -456, 32'h7FFF_FFFF, 32'h8000_0000));
    cmd_queue.push_back(make_cmd(32767, 32767, 32767, 4095, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(-32768, -32768, -32768, 4095, -1, -1, -1, -1));
    cmd_queue.push_back(make_cmd(32767, 0, 0, 2560, half_t, -half_t, half_t + 1, half_t - 1));
    cmd_queue.push_back(make_cmd(1000, 0, 0, 256, half_t, half_t, half_t, half_t));
    cmd_queue.push_back(make_cmd(-1000, 0, 0, 256, 0, half_t / 2, half_t / 2 + 1, 3 * half_t));
    cmd_queue.push_back(make_cmd(0, 1000, 0, 256, 32'h7FFF_FFFF, 32'h7FFF_FF00, 0, 0));
    cmd_queue.push_back(make_cmd(0, -1000, 0, 256, 32'h8000_0000, 32'h8000_0100, 0, 0));
    cmd_queue.push_back(make_cmd(0, 0, 2000, 256, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(0, 0, -2000, 256, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(500, 500, 500, 1, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(32767, -32768, 0, 0, 7, 7, 7, 7));
    drain();

    // Several geometries, extremes and zero ratio and radius among them.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_geometry(500, 500, 144, 55);
        1: set_geometry(4095, 4095, 1023, 1);
        2: set_geometry(1, 1, 1, 1023);
        3: set_geometry(0, 0, 0, 0);
        4: set_geometry(0, 4095, 1023, 1023);
        default: set_geometry($urandom_range(1, 4095), $urandom_range(1, 4095),
                              $urandom_range(1, 1023), $urandom_range(1, 1023));
      endcase
      cmd_queue.push_back(make_cmd(0, 0, 0, 0, 0, 0, 0, 0));
      cmd_queue.push_back(make_cmd(32767, 32767, 32767, 4095, 0, 0, 0, 0));
      for (int n = 0; n < 330; n++) cmd_queue.push_back(random_cmd());
      drain();
    end

    if (errors == 0 && wheel_expect.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/swm_pkg.sv
rtl/core/swm_div.sv
rtl/core/swm_cordic.sv
rtl/core/swm_lane.sv
rtl/core/swerve_module_kinematics.sv
bench/swerve_module_kinematics_tb.sv
